@@ design/mqsb_pkg.sv @@
`timescale 1ns / 1ps

package mqsb_pkg;

    // Fixed widths of the item fields.
    localparam int FUNC_W  = 2;
    localparam int QID_W   = 2;
    localparam int VALUE_W = 32;

    // Default sizes of the shared store.
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_QUEUES     = 4;
    localparam int DEF_DATA_WIDTH = 32;

    // Operation codes. The unused code is handled as an inspect.
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH = 2'd0,
        FN_POP  = 2'd1,
        FN_PEEK = 2'd2
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Status flags handed from the queue state to the result register.
    typedef struct packed {
        t_status status;
        logic    queue_empty;
        logic    store_full;
    } t_flags;

endpackage

@@ design/multi_queue_shared_buffer_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Beat contents
// input     in         i_valid / o_stall   i_func, i_queue_id, i_value
// result    out        o_valid / i_stall   o_status, o_head_value, o_queue_empty,
//                                          o_queue_count, o_store_full
//
// One beat is accepted every cycle while o_stall is low; its result passes the work stage, then the output register.
// The link record store is read through a registered port as the beat enters the work stage.
// Reset is synchronous and active low; the block accepts beats in the cycle after it.
// A stalled result holds the output register, and o_stall rises only when both the
// work stage and the output register are full.

module multi_queue_shared_buffer_core #(
    parameter int ENTRIES    = mqsb_pkg::DEF_ENTRIES,
    parameter int QUEUES     = mqsb_pkg::DEF_QUEUES,
    parameter int DATA_WIDTH = mqsb_pkg::DEF_DATA_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic        [mqsb_pkg::FUNC_W-1:0]   i_func,
    input  logic        [mqsb_pkg::QID_W-1:0]    i_queue_id,
    input  logic signed [mqsb_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic        [1:0]                    o_status,
    output logic signed [mqsb_pkg::VALUE_W-1:0]  o_head_value,
    output logic                                 o_queue_empty,
    output logic        [$clog2(ENTRIES+1)-1:0]  o_queue_count,
    output logic                                 o_store_full
);
    import mqsb_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Work stage.
    logic                  r_s1_vld;
    logic [FUNC_W-1:0]     r_s1_func;
    logic [QID_W-1:0]      r_s1_qid;
    logic [DATA_WIDTH-1:0] r_s1_value;

    // Output register.
    logic                  r_out_vld;
    t_flags                r_out_flags;
    logic [CW-1:0]         r_out_count;
    logic [DATA_WIDTH-1:0] r_out_head;

    logic                  w_s1_adv;
    logic                  w_commit;
    logic                  w_in_acc;
    logic [DATA_WIDTH-1:0] w_in_value;

    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_rd_link;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [AW-1:0]         w_wr_link;
    logic [DATA_WIDTH-1:0] w_wr_data;
    t_flags                w_flags;
    logic [CW-1:0]         w_count;
    logic [DATA_WIDTH-1:0] w_head;

    // Handshake: the work stage moves on whenever the output register is free or draining.
    assign w_s1_adv   = !r_out_vld || !i_stall;
    assign w_commit   = r_s1_vld && w_s1_adv;
    assign o_stall    = r_s1_vld && !w_s1_adv;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_in_value = DATA_WIDTH'($unsigned(i_value));

    // Link record store.
    mqsb_rec_mem #(
        .ENTRIES    (ENTRIES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_rec_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en && w_commit),
        .i_wr_addr (w_wr_addr),
        .i_wr_link (w_wr_link),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_rd_addr),
        .o_rd_link (w_rd_link),
        .o_rd_data (w_rd_data)
    );

    // Queue and free-space state.
    mqsb_qstate #(
        .ENTRIES    (ENTRIES),
        .QUEUES     (QUEUES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_qstate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lk_func (i_func),
        .i_lk_qid  (i_queue_id),
        .o_rd_addr (w_rd_addr),
        .i_commit  (w_commit),
        .i_func    (r_s1_func),
        .i_qid     (r_s1_qid),
        .i_value   (r_s1_value),
        .i_rd_link (w_rd_link),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_link (w_wr_link),
        .o_wr_data (w_wr_data),
        .o_flags   (w_flags),
        .o_count   (w_count),
        .o_head    (w_head)
    );

    // Valid bits of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_commit) begin
                r_s1_vld <= 1'b0;
            end
            if (w_commit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload of the two stages.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_func  <= i_func;
            r_s1_qid   <= i_queue_id;
            r_s1_value <= w_in_value;
        end
        if (w_commit) begin
            r_out_flags <= w_flags;
            r_out_count <= w_count;
            r_out_head  <= w_head;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_out_flags.status;
    assign o_queue_empty = r_out_flags.queue_empty;
    assign o_store_full  = r_out_flags.store_full;
    assign o_queue_count = r_out_count;
    assign o_head_value  = VALUE_W'(r_out_head);

    // A dropped push is only reported against a full store.
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_store_full)
        else $error("push dropped while store not full");

    // A rejected pop always reports an empty queue.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> o_queue_empty && (o_queue_count == '0))
        else $error("pop rejected on a queue that holds entries");

    // The empty flag and the count agree.
    a_count_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_queue_empty == (o_queue_count == '0))
        else $error("empty flag disagrees with count");

    // A beat held in the work stage is neither lost nor altered.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_s1_adv |=> r_s1_vld && $stable(r_s1_value) && $stable(r_s1_qid))
        else $error("work stage beat lost while held");

endmodule

@@ design/mqsb_rec_mem.sv @@
`timescale 1ns / 1ps

module mqsb_rec_mem #(
    parameter int ENTRIES    = mqsb_pkg::DEF_ENTRIES,
    parameter int DATA_WIDTH = mqsb_pkg::DEF_DATA_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0]  i_wr_addr,
    input  logic [$clog2(ENTRIES)-1:0]  i_wr_link,
    input  logic [DATA_WIDTH-1:0]       i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0]  i_rd_addr,
    output logic [$clog2(ENTRIES)-1:0]  o_rd_link,
    output logic [DATA_WIDTH-1:0]       o_rd_data
);
    import mqsb_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    // Each record holds the link to the next entry and the data word of that next entry.
    logic [AW-1:0]         r_link [ENTRIES];
    logic [DATA_WIDTH-1:0] r_data [ENTRIES];
    logic [AW-1:0]         r_rd_link;
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_link[i_wr_addr] <= i_wr_link;
            r_data[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; a write to the same record in the same cycle is passed through.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_link <= i_wr_link;
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_link <= r_link[i_rd_addr];
                r_rd_data <= r_data[i_rd_addr];
            end
        end
    end

    assign o_rd_link = r_rd_link;
    assign o_rd_data = r_rd_data;

endmodule

@@ design/mqsb_qstate.sv @@
`timescale 1ns / 1ps

module mqsb_qstate #(
    parameter int ENTRIES    = mqsb_pkg::DEF_ENTRIES,
    parameter int QUEUES     = mqsb_pkg::DEF_QUEUES,
    parameter int DATA_WIDTH = mqsb_pkg::DEF_DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Lookup for the beat being accepted now.
    input  logic [mqsb_pkg::FUNC_W-1:0]   i_lk_func,
    input  logic [mqsb_pkg::QID_W-1:0]    i_lk_qid,
    output logic [$clog2(ENTRIES)-1:0]    o_rd_addr,
    // Beat held in the work stage.
    input  logic                          i_commit,
    input  logic [mqsb_pkg::FUNC_W-1:0]   i_func,
    input  logic [mqsb_pkg::QID_W-1:0]    i_qid,
    input  logic [DATA_WIDTH-1:0]         i_value,
    input  logic [$clog2(ENTRIES)-1:0]    i_rd_link,
    input  logic [DATA_WIDTH-1:0]         i_rd_data,
    // Record store write.
    output logic                          o_wr_en,
    output logic [$clog2(ENTRIES)-1:0]    o_wr_addr,
    output logic [$clog2(ENTRIES)-1:0]    o_wr_link,
    output logic [DATA_WIDTH-1:0]         o_wr_data,
    // Result of the beat in the work stage.
    output mqsb_pkg::t_flags              o_flags,
    output logic [$clog2(ENTRIES+1)-1:0]  o_count,
    output logic [DATA_WIDTH-1:0]         o_head
);
    import mqsb_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    // Per-queue state.
    logic [AW-1:0]         r_head  [QUEUES];
    logic [AW-1:0]         r_tail  [QUEUES];
    logic [CW-1:0]         r_len   [QUEUES];
    logic [DATA_WIDTH-1:0] r_hdata [QUEUES];
    logic [AW-1:0]         n_head  [QUEUES];
    logic [AW-1:0]         n_tail  [QUEUES];
    logic [CW-1:0]         n_len   [QUEUES];
    logic [DATA_WIDTH-1:0] n_hdata [QUEUES];

    // Free space: a stack of recycled entries plus a count of entries handed out from the never-used part.
    logic [AW-1:0] r_rec_head;
    logic [CW-1:0] r_rec_cnt;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] n_rec_head;
    logic [CW-1:0] n_rec_cnt;
    logic [CW-1:0] n_fill;

    logic [QW-1:0] w_qi;
    logic          w_q_ok;
    logic [QW-1:0] w_lk_qi;
    logic          w_lk_ok;
    logic          w_full;
    logic          w_pop_do;
    logic [AW-1:0] w_alloc;
    t_status       w_status;
    logic [CW-1:0] w_count;

    assign w_qi    = QW'(i_qid);
    assign w_q_ok  = int'(i_qid) < QUEUES;
    assign w_lk_qi = QW'(i_lk_qid);
    assign w_lk_ok = int'(i_lk_qid) < QUEUES;
    assign w_full  = (r_rec_cnt == '0) && (r_fill == CW'(ENTRIES));

    // Update of the queue and free-space state for the beat in the work stage.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_len      = r_len;
        n_hdata    = r_hdata;
        n_rec_head = r_rec_head;
        n_rec_cnt  = r_rec_cnt;
        n_fill     = r_fill;
        o_wr_en    = 1'b0;
        o_wr_addr  = '0;
        o_wr_link  = '0;
        o_wr_data  = i_value;
        w_status   = ST_DONE;
        w_alloc    = '0;
        w_pop_do   = 1'b0;
        if (w_q_ok) begin
            case (t_func'(i_func))
                FN_PUSH: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        if (r_rec_cnt != '0) begin
                            w_alloc    = r_rec_head;
                            n_rec_head = i_rd_link;
                            n_rec_cnt  = r_rec_cnt - CW'(1);
                        end else begin
                            w_alloc = r_fill[AW-1:0];
                            n_fill  = r_fill + CW'(1);
                        end
                        if (r_len[w_qi] == '0) begin
                            n_head[w_qi]  = w_alloc;
                            n_hdata[w_qi] = i_value;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_tail[w_qi];
                            o_wr_link = w_alloc;
                            o_wr_data = i_value;
                        end
                        n_tail[w_qi] = w_alloc;
                        n_len[w_qi]  = r_len[w_qi] + CW'(1);
                    end
                end
                FN_POP: begin
                    if (r_len[w_qi] == '0) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_pop_do = 1'b1;
                        // The old head's record names the next entry and carries its data.
                        if (r_len[w_qi] != CW'(1)) begin
                            n_head[w_qi]  = i_rd_link;
                            n_hdata[w_qi] = i_rd_data;
                        end
                        n_len[w_qi] = r_len[w_qi] - CW'(1);
                        o_wr_en     = 1'b1;
                        o_wr_addr   = r_head[w_qi];
                        o_wr_link   = r_rec_head;
                        n_rec_head  = r_head[w_qi];
                        n_rec_cnt   = r_rec_cnt + CW'(1);
                    end
                end
                FN_PEEK: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Result fields describe the addressed queue after the operation.
    always_comb begin
        w_count = w_q_ok ? n_len[w_qi] : '0;
        o_count = w_count;
        o_head  = (w_count != '0) ? n_hdata[w_qi] : '0;
        o_flags.status      = w_status;
        o_flags.queue_empty = (w_count == '0);
        o_flags.store_full  = (n_rec_cnt == '0) && (n_fill == CW'(ENTRIES));
    end

    // Record lookup for the incoming beat, taken from the state as it stands after this edge.
    always_comb begin
        o_rd_addr = '0;
        if (i_lk_func == FN_PUSH) begin
            o_rd_addr = i_commit ? n_rec_head : r_rec_head;
        end else if (w_lk_ok) begin
            o_rd_addr = i_commit ? n_head[w_lk_qi] : r_head[w_lk_qi];
        end
    end

    // Counts are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '{default: '0};
            r_rec_cnt <= '0;
            r_fill    <= '0;
        end else if (i_commit) begin
            r_len     <= n_len;
            r_rec_cnt <= n_rec_cnt;
            r_fill    <= n_fill;
        end
    end

    // Pointers and head data are only read while their counts say they hold entries.
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_hdata    <= n_hdata;
            r_rec_head <= n_rec_head;
        end
    end

    // The count of entries handed out from the never-used part cannot pass the store size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(ENTRIES))
        else $error("fill count beyond store size");

    // Recycled entries can only come from entries already handed out.
    a_rec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_cnt <= r_fill)
        else $error("recycled count exceeds entries handed out");

    // A completed pop returns exactly one entry to the free stack.
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && w_pop_do |=> r_rec_cnt == $past(r_rec_cnt) + CW'(1))
        else $error("pop did not recycle its entry");

endmodule
